// File: rtl/core/subidx_pkg.sv
// Shared constants and types for the substring index span core.
package subidx_pkg;

  localparam int MAX_DELIM_DEF = 8;
  localparam int MAX_COUNT_DEF = 16;
  localparam int POS_BITS_DEF  = 16;

  localparam int BYTE_W    = 8;
  localparam int DELIM_W   = 64;
  localparam int DLEN_W    = 4;
  localparam int COUNT_W   = 6;
  localparam int CFG_IDX_W = 2;
  localparam int K_W       = 7;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_DELIM_BYTES  = 2'd0;
  localparam cfg_idx_t REG_DELIM_LENGTH = 2'd1;
  localparam cfg_idx_t REG_OCC_COUNT    = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              none;
    logic              last;
  } in_item_t;

endpackage

// File: rtl/core/substring_index_span_core.sv
// Substring index span core: delimiter matcher, match ring and span result stage.
// Path: the item carrying tlast is registered in the input stage at its transaction, and the
// result register, which drives out_tvalid, loads when that item leaves the input stage.
// Throughput: one byte per cycle; a tlast item waits in the input stage only while the
// previous result is still held by out_tready low.
// Reset: synchronous rst_n low clears control state and sets configuration to defaults; ring not reset.
module substring_index_span_core #(
  parameter int MAX_DELIM = subidx_pkg::MAX_DELIM_DEF,
  parameter int MAX_COUNT = subidx_pkg::MAX_COUNT_DEF,
  parameter int POS_BITS  = subidx_pkg::POS_BITS_DEF,
  localparam int OUT_W    = ((2 * POS_BITS + 7) / 8) * 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [subidx_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] in_byte
  input  logic                                  in_tuser,   // [0] no_byte
  input  logic                                  in_tlast,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [OUT_W-1:0]                      out_tdata,  // span_start, span_length
  output logic                                  out_tuser,  // [0] overflow
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [subidx_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [subidx_pkg::DELIM_W-1:0]        cfg_data
);

  localparam int MT_W  = $clog2(MAX_COUNT + 1);
  localparam int PTR_W = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;
  localparam int K_W   = subidx_pkg::K_W;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  // configuration
  logic [subidx_pkg::DELIM_W-1:0] cfg_delim_r;
  logic [subidx_pkg::DLEN_W-1:0]  cfg_dlen_r;
  logic [subidx_pkg::COUNT_W-1:0] cfg_count_r;

  // input stage
  logic                 s1_valid_r;
  subidx_pkg::in_item_t s1_item_r;
  logic                 s1_fire;

  // string state
  logic [subidx_pkg::BYTE_W-1:0] win_r [MAX_DELIM];
  logic [POS_BITS-1:0]           pos_r;
  logic [MT_W-1:0]               mt_r;
  logic [POS_BITS-1:0]           left_pos_r;
  logic                          left_found_r;
  logic                          ovf_r;
  logic [POS_BITS-1:0]           ring_r [MAX_COUNT];
  logic [PTR_W-1:0]              head_r;

  // next values after this item
  logic [subidx_pkg::BYTE_W-1:0] win_nxt [MAX_DELIM];
  logic [POS_BITS-1:0]           pos_nxt;
  logic [MT_W-1:0]               mt_nxt;
  logic [POS_BITS-1:0]           left_pos_nxt;
  logic                          left_found_nxt;
  logic                          ovf_nxt;
  logic [PTR_W-1:0]              head_nxt;
  logic                          hit;

  // result
  logic                out_valid_r;
  logic [POS_BITS-1:0] out_start_r;
  logic [POS_BITS-1:0] out_len_r;
  logic                out_ovf_r;
  logic [POS_BITS-1:0] start_nxt;
  logic [POS_BITS-1:0] len_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_delim_r <= '0;
      cfg_dlen_r  <= subidx_pkg::DLEN_W'(1);
      cfg_count_r <= subidx_pkg::COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        subidx_pkg::REG_DELIM_BYTES:  cfg_delim_r <= cfg_data;
        subidx_pkg::REG_DELIM_LENGTH: cfg_dlen_r  <= cfg_data[subidx_pkg::DLEN_W-1:0];
        subidx_pkg::REG_OCC_COUNT:    cfg_count_r <= cfg_data[subidx_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // a last item moves on only when the result register is free
  assign s1_fire   = s1_valid_r && (!s1_item_r.last || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_item_r.data <= in_tdata;
      s1_item_r.none <= in_tuser;
      s1_item_r.last <= in_tlast;
    end
  end

  always_comb begin
    logic [subidx_pkg::DLEN_W-1:0]  dlen;
    logic [2:0]                     sel;
    logic [subidx_pkg::COUNT_W-1:0] mag;
    logic [K_W-1:0]                 k;
    logic                           c_pos;
    logic                           c_neg;
    logic [PTR_W-1:0]               rd_idx;
    logic [POS_BITS-1:0]            rd_pos;

    if (cfg_dlen_r == '0) begin
      dlen = subidx_pkg::DLEN_W'(1);
    end else if (cfg_dlen_r > subidx_pkg::DLEN_W'(MAX_DELIM)) begin
      dlen = subidx_pkg::DLEN_W'(MAX_DELIM);
    end else begin
      dlen = cfg_dlen_r;
    end

    c_neg = cfg_count_r[subidx_pkg::COUNT_W-1];
    c_pos = !c_neg && (cfg_count_r != '0);
    mag   = c_neg ? (~cfg_count_r + subidx_pkg::COUNT_W'(1)) : cfg_count_r;
    k     = ({1'b0, mag} > K_W'(MAX_COUNT)) ? K_W'(MAX_COUNT) : {1'b0, mag};

    win_nxt = win_r;
    pos_nxt = pos_r;
    ovf_nxt = ovf_r;
    if (!s1_item_r.none) begin
      if (pos_r == POS_MAX) begin
        ovf_nxt = 1'b1;
      end else begin
        pos_nxt = pos_r + POS_BITS'(1);
      end
      win_nxt[0] = s1_item_r.data;
      for (int i = 1; i < MAX_DELIM; i++) begin
        win_nxt[i] = win_r[i-1];
      end
    end

    hit = !s1_item_r.none && (pos_nxt >= POS_BITS'(dlen));
    for (int i = 0; i < MAX_DELIM; i++) begin
      sel = 3'(dlen - subidx_pkg::DLEN_W'(i) - subidx_pkg::DLEN_W'(1));
      if (subidx_pkg::DLEN_W'(i) < dlen) begin
        if (win_nxt[i] != cfg_delim_r[{sel, 3'b000} +: subidx_pkg::BYTE_W]) begin
          hit = 1'b0;
        end
      end
    end

    mt_nxt         = mt_r;
    head_nxt       = head_r;
    left_pos_nxt   = left_pos_r;
    left_found_nxt = left_found_r;
    if (hit) begin
      if (mt_r < MT_W'(MAX_COUNT)) begin
        mt_nxt = mt_r + MT_W'(1);
      end
      head_nxt = (head_r == PTR_W'(MAX_COUNT - 1)) ? '0 : head_r + PTR_W'(1);
      if (c_pos && !left_found_r && (K_W'(mt_nxt) == k)) begin
        left_pos_nxt   = pos_nxt - POS_BITS'(dlen);
        left_found_nxt = 1'b1;
      end
    end

    if (K_W'(head_nxt) >= k) begin
      rd_idx = PTR_W'(K_W'(head_nxt) - k);
    end else begin
      rd_idx = PTR_W'(K_W'(head_nxt) + K_W'(MAX_COUNT) - k);
    end
    rd_pos = (hit && rd_idx == head_r) ? pos_nxt : ring_r[rd_idx];
    if (rd_pos > pos_nxt) begin
      rd_pos = pos_nxt;
    end

    start_nxt = '0;
    len_nxt   = pos_nxt;
    if (!c_pos && !c_neg) begin
      len_nxt = '0;
    end else if (c_pos) begin
      if (left_found_nxt) begin
        len_nxt = left_pos_nxt;
      end
    end else if (K_W'(mt_nxt) >= k) begin
      start_nxt = rd_pos;
      len_nxt   = pos_nxt - rd_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      mt_r         <= '0;
      left_pos_r   <= '0;
      left_found_r <= 1'b0;
      ovf_r        <= 1'b0;
      head_r       <= '0;
      for (int i = 0; i < MAX_DELIM; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_fire) begin
      head_r <= head_nxt;
      if (s1_item_r.last) begin
        pos_r        <= '0;
        mt_r         <= '0;
        left_pos_r   <= '0;
        left_found_r <= 1'b0;
        ovf_r        <= 1'b0;
        for (int i = 0; i < MAX_DELIM; i++) begin
          win_r[i] <= '0;
        end
      end else begin
        pos_r        <= pos_nxt;
        mt_r         <= mt_nxt;
        left_pos_r   <= left_pos_nxt;
        left_found_r <= left_found_nxt;
        ovf_r        <= ovf_nxt;
        win_r        <= win_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && hit) begin
      ring_r[head_r] <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (out_valid_r && !out_tready) || (s1_fire && s1_item_r.last);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_item_r.last) begin
      out_start_r <= start_nxt;
      out_len_r   <= len_nxt;
      out_ovf_r   <= ovf_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_len_r, out_start_r});
  assign out_tuser  = out_ovf_r;

`ifndef SYNTHESIS
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_item_r.last |=> out_valid_r)
    else $error("last item did not load a result");

  a_last_clears_string: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_item_r.last |=> pos_r == '0 && mt_r == '0 && !left_found_r)
    else $error("string state not cleared after last item");

  a_match_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> mt_r <= MT_W'(MAX_COUNT))
    else $error("match total above limit");

  a_left_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
    left_found_r |-> mt_r != '0)
    else $error("left hit recorded without a match");
`endif

endmodule

// File: verif/substring_index_span_core_tb.sv
// Self-checking testbench for substring_index_span_core: directed table and random strings.
`timescale 1ns / 1ps

module substring_index_span_core_tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 1200;
  localparam logic [15:0] POS_TOP = 16'hFFFF;

  typedef struct packed {
    logic [15:0] span_start;
    logic [15:0] span_len;
    logic        ovf;
  } span_t;

  typedef struct packed {
    logic        cfg;
    logic [63:0] delim;
    logic [3:0]  dlen;
    logic [5:0]  occ;
    logic [7:0]  data;
    logic        none;
    logic        last;
    logic        chk;
    logic [15:0] exp_start;
    logic [15:0] exp_len;
    logic        exp_ovf;
  } dir_row_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata   = '0;
  logic                 in_tuser   = 1'b0;
  logic                 in_tlast   = 1'b0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [31:0]          out_tdata;
  logic                 out_tuser;
  logic                 cfg_valid  = 1'b0;
  logic                 cfg_ready;
  subidx_pkg::cfg_idx_t cfg_index  = subidx_pkg::REG_DELIM_BYTES;
  logic [63:0]          cfg_data   = '0;

  substring_index_span_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // span predictor state
  logic [63:0]        delim_reg     = '0;
  logic [3:0]         delim_len_reg = 4'd1;
  logic signed [5:0]  occ_reg       = 6'sd1;
  logic [7:0]         win_bytes [8] = '{default: '0};
  logic [15:0]        bytes_seen    = '0;
  logic [4:0]         hit_count     = '0;
  logic [15:0]        hit_ends [16] = '{default: '0};
  logic [3:0]         hit_head      = '0;
  logic [15:0]        first_cut     = '0;
  logic               first_cut_found = 1'b0;
  logic               pos_saturated = 1'b0;

  span_t span_q [$];
  span_t pin_span;
  logic  pin_on = 1'b0;

  int errors     = 0;
  int quiet      = 0;
  int items_sent = 0;
  int burst_left = 0;
  logic idle_on  = 1'b1;
  logic [63:0] cur_delim = '0;
  int cur_dlen = 1;

  logic [31:0] rdy_pat  = '1;
  int          rdy_hold = 0;

  dir_row_t dir_rows [24] = '{
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'h00, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'h00, 1'b1, 1'b1, 1'b1, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'hFF, 1'b1, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'hFF, 1'b0, 1'b1, 1'b1, 16'd0, 16'd1, 1'b0},
    '{1'b1, 64'h6261, 4'd2, 6'h02, 8'h78, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'h61, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'h62, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'h79, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'h61, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'h62, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'h7A, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 6'h3F, 8'hFF, 1'b0, 1'b0, 1'b0,
      16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'hFF, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b0, 64'h0, 4'd0, 6'h00, 8'hFF, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0, 1'b0},
    '{1'b1, 64'h61, 4'd0, 6'h00, 8'h61, 1'b0, 1'b1, 1'b1, 16'd0, 16'd0, 1'b0},
    '{1'b1, 64'h61, 4'd1, 6'h1F, 8'h61, 1'b0, 1'b1, 1'b1, 16'd0, 16'd1, 1'b0},
    '{1'b1, 64'h61, 4'd1, 6'h20, 8'h61, 1'b0, 1'b1, 1'b1, 16'd0, 16'd1, 1'b0},
    '{1'b1, 64'h0, 4'd2, 6'h01, 8'h00, 1'b0, 1'b1, 1'b1, 16'd0, 16'd1, 1'b0}
  };

  function automatic void span_take_byte(input logic [7:0] b);
    int d;
    int i;
    int c;
    int k;
    logic hit;
    d = (delim_len_reg == 0) ? 1 : (delim_len_reg > 8) ? 8 : int'(delim_len_reg);
    if (bytes_seen == POS_TOP) pos_saturated = 1'b1;
    else bytes_seen++;
    for (i = 7; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = b;
    if (bytes_seen < d) return;
    hit = 1'b1;
    for (i = 0; i < d; i++)
      if (win_bytes[i] != delim_reg[8*(d-1-i) +: 8]) hit = 1'b0;
    if (!hit) return;
    hit_ends[hit_head] = bytes_seen;
    hit_head++;
    if (hit_count < 16) hit_count++;
    c = occ_reg;
    if (c > 0 && !first_cut_found) begin
      k = (c > 16) ? 16 : c;
      if (hit_count == k) begin
        first_cut = bytes_seen - 16'(d);
        first_cut_found = 1'b1;
      end
    end
  endfunction

  function automatic span_t span_close_string();
    span_t r;
    int c;
    int k;
    logic [3:0] idx;
    logic [15:0] e;
    r.span_start = '0;
    r.span_len = bytes_seen;
    r.ovf = pos_saturated;
    c = occ_reg;
    if (c == 0) begin
      r.span_len = '0;
    end else if (c > 0) begin
      if (first_cut_found) r.span_len = first_cut;
    end else begin
      k = (-c > 16) ? 16 : -c;
      if (hit_count >= k) begin
        idx = hit_head - 4'(k);
        e = hit_ends[idx];
        if (e > bytes_seen) e = bytes_seen;
        r.span_start = e;
        r.span_len = bytes_seen - e;
      end
    end
    win_bytes = '{default: '0};
    bytes_seen = '0;
    hit_count = '0;
    first_cut = '0;
    first_cut_found = 1'b0;
    pos_saturated = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    span_t want;
    span_t got;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          subidx_pkg::REG_DELIM_BYTES:  delim_reg = cfg_data;
          subidx_pkg::REG_DELIM_LENGTH: delim_len_reg = cfg_data[3:0];
          subidx_pkg::REG_OCC_COUNT:    occ_reg = cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (!in_tuser) span_take_byte(in_tdata);
        if (in_tlast) begin
          want = span_close_string();
          span_q.push_back(pin_on ? pin_span : want);
        end
      end
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[15:0], out_tdata[31:16], out_tuser};
        if (span_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual start %0d length %0d ovf %0b",
                   $time, got.span_start, got.span_len, got.ovf);
        end else begin
          want = span_q.pop_front();
          if (got.span_start !== want.span_start) begin
            errors++;
            $display("%0t: span_start expected %0d actual %0d", $time, want.span_start,
                     got.span_start);
          end
          if (got.span_len !== want.span_len) begin
            errors++;
            $display("%0t: span_length expected %0d actual %0d", $time, want.span_len,
                     got.span_len);
          end
          if (got.ovf !== want.ovf) begin
            errors++;
            $display("%0t: overflow expected %0b actual %0b", $time, want.ovf, got.ovf);
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, quiet);
        $display("substring_index_span_core: mismatch");
        $finish;
      end
    end
  end

  // receiver backpressure: rotating pattern, redrawn now and then
  always @(negedge clk) begin
    if (rdy_hold == 0) begin
      rdy_hold <= $urandom_range(16, 200);
      case ($urandom_range(0, 3))
        0: rdy_pat <= '1;
        1: rdy_pat <= $urandom | 32'h1;
        2: rdy_pat <= ($urandom & $urandom) | 32'h1;
        default: rdy_pat <= 32'h0001_0001;
      endcase
    end else begin
      rdy_hold <= rdy_hold - 1;
      rdy_pat <= {rdy_pat[30:0], rdy_pat[31]};
    end
    out_tready <= rdy_pat[0];
  end

  task automatic send_item(input logic [7:0] b, input logic nb, input logic lst);
    if (idle_on) begin
      if (burst_left == 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        burst_left = $urandom_range(1, 16);
      end
      burst_left--;
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= nb;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    pin_on = 1'b0;
    if (!nb || lst) items_sent++;
  endtask

  // hold off input until every pending result has drained
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (span_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input subidx_pkg::cfg_idx_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic configure(input logic [63:0] db, input logic [63:0] dl,
                           input logic [63:0] oc);
    write_reg(subidx_pkg::REG_DELIM_BYTES, db);
    write_reg(subidx_pkg::REG_DELIM_LENGTH, dl);
    write_reg(subidx_pkg::REG_OCC_COUNT, oc);
    cfg_valid <= 1'b0;
    cur_delim = db;
    cur_dlen = (dl[3:0] == 0) ? 1 : (dl[3:0] > 8) ? 8 : int'(dl[3:0]);
  endtask

  task automatic random_config();
    logic [63:0] db;
    logic [63:0] dl;
    logic [63:0] oc;
    int c;
    int pick;
    db = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) db = {8{db[7:0]}};
    dl = {$urandom, $urandom};
    dl[3:0] = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 8));
    pick = $urandom_range(0, 9);
    if (pick < 7) c = int'($urandom_range(0, 12)) - 6;
    else if (pick < 9) c = int'($urandom_range(0, 34)) - 17;
    else c = $urandom_range(0, 63);
    oc = {$urandom, $urandom};
    oc[5:0] = c[5:0];
    wait_idle();
    configure(db, dl, oc);
  endtask

  // mostly delimiter-rich strings; some noise, broken delimiters and ignored items
  task automatic send_string();
    logic [7:0] body [$];
    int n;
    int i;
    int kind;
    int part;
    logic noise;
    logic tail_none;
    noise = ($urandom_range(0, 6) == 0);
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 24);
    while (body.size() < n) begin
      kind = noise ? 9 : $urandom_range(0, 9);
      if (kind < 4) begin
        for (i = 0; i < cur_dlen; i++) body.push_back(cur_delim[8*i +: 8]);
      end else if (kind < 5 && cur_dlen > 1) begin
        part = $urandom_range(1, cur_dlen - 1);
        for (i = 0; i < part; i++) body.push_back(cur_delim[8*i +: 8]);
      end else if (kind < 8) begin
        body.push_back(cur_delim[8*$urandom_range(0, cur_dlen - 1) +: 8]);
      end else begin
        body.push_back(8'($urandom));
      end
    end
    tail_none = (body.size() == 0) || ($urandom_range(0, 15) == 0);
    for (i = 0; i < body.size(); i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b1, 1'b0);
      send_item(body[i], 1'b0, !tail_none && (i == body.size() - 1));
    end
    if (tail_none) send_item(8'($urandom), 1'b1, 1'b1);
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].cfg) begin
        wait_idle();
        configure(dir_rows[r].delim, 64'(dir_rows[r].dlen), 64'(dir_rows[r].occ));
      end
      pin_on = dir_rows[r].chk;
      pin_span = '{dir_rows[r].exp_start, dir_rows[r].exp_len, dir_rows[r].exp_ovf};
      send_item(dir_rows[r].data, dir_rows[r].none, dir_rows[r].last);
    end

    while (items_sent < RANDOM_ITEMS + $size(dir_rows)) begin
      random_config();
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(3, 8)) send_string();
    end

    wait_idle();
    repeat (6) @(negedge clk);
    if (errors == 0)
      $display("substring_index_span_core: match");
    else
      $display("substring_index_span_core: mismatch");
    $finish;
  end

endmodule

// File: files.f
rtl/core/subidx_pkg.sv
rtl/core/substring_index_span_core.sv
verif/substring_index_span_core_tb.sv
